FILE: rtl/istk_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// istk_pkg: shared types and constants for the indexed stack engine
// Depth, widths, request and status codes, control bundle between units.
// ---------------------------------------------------------------------------
package istk_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;
	localparam int POS_W  = 4;
	localparam int KIND_W = 3;
	localparam int STAT_W = 2;
	localparam int CMP_W  = POS_W + CNT_W;

	localparam int IN_BITS      = WORD_W + POS_W;
	localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
	localparam int IN_TUSER_W   = KIND_W;
	localparam int OUT_BITS     = STAT_W + WORD_W + CNT_W;
	localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [IDX_W-1:0]         idx_t;

	typedef enum logic [KIND_W-1:0] {
		K_PUSH     = 3'd0,
		K_POP      = 3'd1,
		K_INS_BOT  = 3'd2,
		K_INS_AT   = 3'd3,
		K_REM_BOT  = 3'd4,
		K_REM_AT   = 3'd5,
		K_REVERSE  = 3'd6
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_NOPOS = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_INS  = 2'd1,
		OP_REM  = 2'd2,
		OP_REV  = 2'd3
	} op_t;

	// what the storage array must do for one request
	typedef struct packed {
		op_t  op;
		idx_t at;
		logic pop;
	} ctl_t;

endpackage
`default_nettype wire

FILE: rtl/istk_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// istk_ctrl: request decode
// Checks a request against the fill count, picks the status, the new count
// and the array operation.
// ---------------------------------------------------------------------------
module istk_ctrl
	import istk_pkg::*;
(
	input  wire logic [KIND_W-1:0] kind,
	input  wire logic [POS_W-1:0]  position,
	input  wire cnt_t              fill,
	output status_t                status,
	output cnt_t                   fill_nxt,
	output ctl_t                   ctl
);

	logic empty;
	logic full;
	logic pos_bad;

	assign empty   = (fill == '0);
	assign full    = (fill >= CNT_W'(DEPTH));
	assign pos_bad = (CMP_W'(position) >= CMP_W'(fill));

	always_comb begin
		status   = ST_OK;
		fill_nxt = fill;
		ctl.op   = OP_NONE;
		ctl.at   = '0;
		ctl.pop  = 1'b0;
		case (kind)
			K_PUSH: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					ctl.op   = OP_INS;
					ctl.at   = fill[IDX_W-1:0];
					fill_nxt = fill + 1'b1;
				end
			end
			K_POP: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					ctl.pop  = 1'b1;
					fill_nxt = fill - 1'b1;
				end
			end
			K_INS_BOT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					ctl.op   = OP_INS;
					fill_nxt = fill + 1'b1;
				end
			end
			K_INS_AT: begin
				// an empty stack still takes an insert at the bottom slot
				if (pos_bad && !(empty && position == '0)) begin
					status = ST_NOPOS;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					ctl.op   = OP_INS;
					ctl.at   = IDX_W'(position);
					fill_nxt = fill + 1'b1;
				end
			end
			K_REM_BOT: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					ctl.op   = OP_REM;
					fill_nxt = fill - 1'b1;
				end
			end
			K_REM_AT: begin
				if (empty) begin
					status = ST_EMPTY;
				end else if (pos_bad) begin
					status = ST_NOPOS;
				end else begin
					ctl.op   = OP_REM;
					ctl.at   = IDX_W'(position);
					fill_nxt = fill - 1'b1;
				end
			end
			K_REVERSE: begin
				ctl.op = OP_REV;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/istk_array.sv
`default_nettype none
// ---------------------------------------------------------------------------
// istk_array: entry storage
// One register per entry, each with its own shift/insert/mirror selector so
// any operation updates all entries together.
// ---------------------------------------------------------------------------
module istk_array
	import istk_pkg::*;
(
	input  wire logic clk,
	input  wire logic en,
	input  wire ctl_t ctl,
	input  wire cnt_t fill,
	input  wire word_t word,
	output word_t     top_rd
);

	word_t entries_q [DEPTH];
	word_t entries_nxt [DEPTH];
	cnt_t  top_idx;

	assign top_idx = fill - 1'b1;
	assign top_rd  = entries_q[top_idx[IDX_W-1:0]];

	for (genvar i = 0; i < DEPTH; i++) begin : g_ent
		word_t below_w;
		word_t above_w;
		cnt_t  mir_idx;

		if (i > 0) begin : g_lo
			assign below_w = entries_q[i-1];
		end else begin : g_lo0
			assign below_w = '0;
		end

		if (i < DEPTH - 1) begin : g_hi
			assign above_w = entries_q[i+1];
		end else begin : g_hiN
			assign above_w = '0;
		end

		// mirror partner, only meaningful below the fill level
		assign mir_idx = fill - CNT_W'(i + 1);

		always_comb begin
			entries_nxt[i] = entries_q[i];
			case (ctl.op)
				OP_INS: begin
					if (IDX_W'(i) == ctl.at) begin
						entries_nxt[i] = word;
					end else if (IDX_W'(i) > ctl.at && CNT_W'(i) <= fill) begin
						entries_nxt[i] = below_w;
					end
				end
				OP_REM: begin
					if (IDX_W'(i) >= ctl.at && CNT_W'(i + 1) < fill) begin
						entries_nxt[i] = above_w;
					end
				end
				OP_REV: begin
					if (CNT_W'(i) < fill) begin
						entries_nxt[i] = entries_q[mir_idx[IDX_W-1:0]];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			entries_q <= entries_nxt;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/indexed_stack_engine.sv
`default_nettype none
// ---------------------------------------------------------------------------
// indexed_stack_engine: bounded stack with indexed insert and remove
// Request beat lands in _s1, result in _s2; one request per cycle sustained
// while _s2 is free or drained, as the fill count and entries update in the
// same edge that registers the result. Reset clears the fill count and both
// valid flags; entries are not reset and only those below the count are read.
// ---------------------------------------------------------------------------
module indexed_stack_engine
	import istk_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// request side
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // value[31:0], position[35:32], zero pad
	input  wire logic [IN_TUSER_W-1:0]  s_tuser,   // kind[2:0]
	// result side
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata    // status[1:0], top_word[33:2],
	                                                // entry_count[38:34], zero pad
);

	// Pipeline: request beat lands in the _s1 register; decode, the entry
	// selectors and the fill update all sit between _s1 and the result
	// register _s2. The whole pipe advances whenever _s2 is free or drained.

	logic                 valid_s1;
	logic [KIND_W-1:0]    kind_s1;
	word_t                value_s1;
	logic [POS_W-1:0]     position_s1;

	logic                 valid_s2;
	status_t              status_s2;
	word_t                top_word_s2;
	cnt_t                 count_s2;

	cnt_t                 fill_q;

	logic                 adv;
	logic                 fire;
	status_t              status;
	cnt_t                 fill_nxt;
	ctl_t                 ctl;
	word_t                top_rd;

	assign adv      = !valid_s2 || m_tready;
	assign fire     = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1     <= s_tuser[KIND_W-1:0];
			value_s1    <= s_tdata[WORD_W-1:0];
			position_s1 <= s_tdata[WORD_W +: POS_W];
		end
	end

	// decode against the live count
	istk_ctrl u_ctrl (
		.kind     (kind_s1),
		.position (position_s1),
		.fill     (fill_q),
		.status   (status),
		.fill_nxt (fill_nxt),
		.ctl      (ctl)
	);

	// entries are only written on a beat that actually moves on
	istk_array u_array (
		.clk    (clk),
		.en     (fire),
		.ctl    (ctl),
		.fill   (fill_q),
		.word   (value_s1),
		.top_rd (top_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (fire) begin
			fill_q <= fill_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s2   <= status;
			top_word_s2 <= ctl.pop ? top_rd : '0;
			count_s2    <= fill_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = OUT_TDATA_W'({count_s2, top_word_s2, status_s2});

	// ---------------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------------

	// count never runs past the storage
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("fill count beyond depth");

	// a refused request leaves the count alone
	a_fail_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		fire && status != ST_OK |=> fill_q == $past(fill_q))
		else $error("failed request changed the count");

	// the registered count matches the state it was taken from
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> count_s2 == fill_q)
		else $error("result count differs from stored count");

	// only a good pop carries a word
	a_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && status_s2 != ST_OK |-> top_word_s2 == '0)
		else $error("word returned on a failed request");

endmodule
`default_nettype wire
